// ===== hw/rtl/lrsk_pkg.sv =====
// ----------------------------------------------------------------------------
// lrsk_pkg: shared types and constants of the linked RMS compressor
// Payload structs, lane control, register indexes and the log2/exp2 tables.
// ----------------------------------------------------------------------------
package lrsk_pkg;

    localparam int LANES       = 8;
    localparam int LANE_IDX_W  = 3;
    localparam int SAMPLE_BITS = 24;
    localparam int SQ_W        = 47;
    localparam int SUM_W       = 50;
    localparam int DIV_NUM_W   = 50;
    localparam int DIV_DEN_W   = 34;
    localparam int MANT_W      = 18;
    localparam int MAG_W       = SAMPLE_BITS + MANT_W;

    typedef enum logic [2:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_INV_RATIO = 3'd1,
        CFG_KNEE      = 3'd2,
        CFG_ATTACK    = 3'd3,
        CFG_RELEASE   = 3'd4,
        CFG_DETECTOR  = 3'd5,
        CFG_MAKEUP    = 3'd6
    } lrsk_cfg_idx_t;

    typedef struct packed {
        logic [3:0]                    active_channels;
        logic signed [SAMPLE_BITS-1:0] sample_0;
        logic signed [SAMPLE_BITS-1:0] sample_1;
        logic signed [SAMPLE_BITS-1:0] sample_2;
        logic signed [SAMPLE_BITS-1:0] sample_3;
        logic signed [SAMPLE_BITS-1:0] sample_4;
        logic signed [SAMPLE_BITS-1:0] sample_5;
        logic signed [SAMPLE_BITS-1:0] sample_6;
        logic signed [SAMPLE_BITS-1:0] sample_7;
    } lrsk_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_sample_0;
        logic signed [SAMPLE_BITS-1:0] out_sample_1;
        logic signed [SAMPLE_BITS-1:0] out_sample_2;
        logic signed [SAMPLE_BITS-1:0] out_sample_3;
        logic signed [SAMPLE_BITS-1:0] out_sample_4;
        logic signed [SAMPLE_BITS-1:0] out_sample_5;
        logic signed [SAMPLE_BITS-1:0] out_sample_6;
        logic signed [SAMPLE_BITS-1:0] out_sample_7;
        logic signed [15:0]            applied_gain_db;
    } lrsk_out_t;

    typedef struct packed {
        logic              load;
        logic [MANT_W-1:0] mant;
        logic [5:0]        shamt;
        logic              rnd;
    } lrsk_lane_ctrl_t;

    function automatic logic [16:0] log2_tab(input logic [4:0] idx);
        logic [16:0] v;
        unique case (idx)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30109;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56229;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    function automatic logic [17:0] exp2_tab(input logic [4:0] idx);
        logic [17:0] v;
        unique case (idx)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/lrsk_lane.sv =====
// ----------------------------------------------------------------------------
// lrsk_lane: one channel lane
// Holds a channel sample, squares its magnitude for the detector and scales it
// by the linear gain with rounding and saturation.
// ----------------------------------------------------------------------------
module lrsk_lane (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [lrsk_pkg::SAMPLE_BITS-1:0]      sample,
    input  logic                                  active,
    input  lrsk_pkg::lrsk_lane_ctrl_t             ctrl,
    output logic [lrsk_pkg::SQ_W-1:0]             square,
    output logic [lrsk_pkg::SAMPLE_BITS-1:0]      result
);
    import lrsk_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] LIM = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   active_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [MAG_W-1:0]       mag_reg;
    logic [SAMPLE_BITS-1:0] out_reg;

    logic                   neg;
    logic [SAMPLE_BITS-1:0] mag_abs;
    logic [MAG_W+6:0]       ext;
    logic [MAG_W+6:0]       addend;
    logic [MAG_W+6:0]       shifted;
    logic [SAMPLE_BITS-1:0] rsat;
    logic [SAMPLE_BITS-1:0] out_next;

    assign neg     = sample_reg[SAMPLE_BITS-1];
    assign mag_abs = neg ? (~sample_reg + SAMPLE_BITS'(1)) : sample_reg;

    // The product is pre-shifted left by six so that left shifts of the gain
    // become right shifts with no rounding term.
    always_comb
    begin
        ext     = {1'b0, mag_reg, 6'b0};
        addend  = ctrl.rnd ? ((MAG_W+7)'(1) << (ctrl.shamt - 6'd1)) : '0;
        shifted = (ext + addend) >> ctrl.shamt;
        rsat    = (shifted > (MAG_W+7)'(LIM)) ? LIM : shifted[SAMPLE_BITS-1:0];
        if (!active_reg)
        begin
            out_next = '0;
        end
        else if (neg)
        begin
            out_next = ~rsat + SAMPLE_BITS'(1);
        end
        else if (rsat == LIM)
        begin
            out_next = LIM - SAMPLE_BITS'(1);
        end
        else
        begin
            out_next = rsat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            active_reg <= active;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sample_reg <= sample;
        end
        sq_reg  <= active_reg ? (SQ_W'(mag_abs) * SQ_W'(mag_abs)) : '0;
        mag_reg <= MAG_W'(mag_abs) * MAG_W'(ctrl.mant);
        out_reg <= out_next;
    end

    assign square = sq_reg;
    assign result = out_reg;

endmodule

// ===== hw/rtl/lrsk_div.sv =====
// ----------------------------------------------------------------------------
// lrsk_div: iterative unsigned divider
// Restoring division, two quotient bits per clock, shared by the channel
// averaging and the soft-knee curve.
// ----------------------------------------------------------------------------
module lrsk_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [lrsk_pkg::DIV_NUM_W-1:0]   num,
    input  logic [lrsk_pkg::DIV_DEN_W-1:0]   den,
    output logic                             done,
    output logic [lrsk_pkg::DIV_NUM_W-1:0]   quo
);
    import lrsk_pkg::*;

    localparam int STEPS = DIV_NUM_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_DEN_W:0]   rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;

    logic [DIV_DEN_W:0]   rem_next;
    logic [DIV_NUM_W-1:0] quo_next;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < 2; i++)
        begin
            rem_next = {rem_next[DIV_DEN_W-1:0], quo_next[DIV_NUM_W-1]};
            quo_next = {quo_next[DIV_NUM_W-2:0], 1'b0};
            if (rem_next >= {1'b0, den_reg})
            begin
                rem_next    = rem_next - {1'b0, den_reg};
                quo_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== hw/rtl/linked_rms_soft_knee_compressor_top.sv =====
// ----------------------------------------------------------------------------
// linked_rms_soft_knee_compressor_top: linked RMS compressor with soft knee
// One multichannel frame in, one gain-scaled frame and its applied gain out.
// ----------------------------------------------------------------------------
// A frame takes longer from acceptance to result when the detected level falls
// inside the soft knee; the block works on one frame at a time and accepts the
// next one as soon as the result is in the output register. The time is set by
// the shared two-bit-per-cycle divider, used once for the channel average and
// once more for the knee curve, by the merge of the eight lane squares, the
// six-step level normalizer, and the single shared multiplier that carries the
// detector, log, curve, smoothing and exp steps. Configuration may be written
// whenever no frame is in flight.
module linked_rms_soft_knee_compressor_top #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  lrsk_pkg::lrsk_in_t        in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output lrsk_pkg::lrsk_out_t       out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [24:0]               cfg_data
);
    import lrsk_pkg::*;

    localparam logic [3:0]  MAX_ACT  = 4'(MAX_CHANNELS);
    localparam logic [24:0] ONE_Q24  = 25'd16777216;
    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [46:0] MS_FLOOR = 47'd70;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ, ST_SUM, ST_AVG, ST_AVG_WAIT, ST_DET_DIFF, ST_DET_HI,
        ST_DET_LO, ST_DET_UPD, ST_LOG_START, ST_LOG_NORM, ST_LOG_MUL, ST_LOG_DB,
        ST_LOG_DBM, ST_LOG_LEV, ST_CURVE, ST_KNEE_SQ, ST_KNEE_NUM, ST_KNEE_DIV,
        ST_KNEE_WAIT, ST_LIN_MUL, ST_LIN_RND, ST_SMOOTH, ST_SMOOTH_UPD,
        ST_EXP_MUL, ST_EXP_FRAC, ST_EXP_MANT, ST_EXP_SUM, ST_SCALE_MUL,
        ST_SCALE_SHF, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        CRV_ZERO, CRV_KNEE, CRV_LINEAR
    } curve_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic signed [15:0] thr_reg;
    logic [16:0]        ir_reg;
    logic [13:0]        knee_reg;
    logic [24:0]        att_reg;
    logic [24:0]        rel_reg;
    logic [24:0]        det_reg;
    logic [14:0]        mk_reg;

    // Control and persistent state.
    logic [LANE_IDX_W-1:0] cnt_reg;
    logic [2:0]            nstep_reg;
    logic [3:0]            act_reg;
    logic [46:0]           ms_reg;
    logic signed [16:0]    g_reg;
    logic                  out_valid_reg;
    curve_t                crv_reg;

    // Datapath registers.
    logic [SUM_W-1:0]   sum_reg;
    logic [54:0]        prod_reg;
    logic [46:0]        dlt_reg;
    logic               up_reg;
    logic [48:0]        phi_reg;
    logic [47:0]        norm_reg;
    logic [5:0]         z_reg;
    logic [21:0]        d_reg;
    logic signed [15:0] level_reg;
    logic [14:0]        t2_reg;
    logic [15:0]        ovp_reg;
    logic signed [16:0] target_reg;
    logic               neg_reg;
    logic signed [16:0] a_reg;
    logic [23:0]        eo_reg;
    logic [MANT_W-1:0]  mant_reg;
    lrsk_out_t          out_data_reg;

    // Lanes.
    logic [SAMPLE_BITS-1:0] samples [LANES];
    logic [SQ_W-1:0]        lane_sq [LANES];
    logic [SAMPLE_BITS-1:0] lane_out [LANES];
    lrsk_lane_ctrl_t        lane_ctrl;
    logic [3:0]             act_in;
    logic                   accept;

    // Divider.
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    // Shared multiplier.
    logic [29:0] mul_a;
    logic [24:0] mul_b;

    // Combinational helpers.
    logic [24:0]        det_c;
    logic [46:0]        inst;
    logic [48:0]        det_low;
    logic [47:0]        det_step;
    logic [16:0]        ir_c;
    logic [16:0]        slope;
    logic signed [16:0] ov;
    logic [16:0]        aov;
    logic signed [17:0] t2_full;
    logic [16:0]        frac;
    logic [22:0]        lg;
    logic [22:0]        lg_max;
    logic [16:0]        m_db;
    logic signed [17:0] sdiff;
    logic [17:0]        adiff;
    logic [24:0]        sm_c;
    logic [17:0]        sm_step;
    logic signed [17:0] g_new;
    logic signed [16:0] a_new;
    logic [16:0]        a_abs;
    logic [20:0]        emag;
    logic signed [23:0] e_val;
    logic [7:0]         eo_hi;
    logic [4:0]         log_idx;
    logic [4:0]         exp_idx;
    logic               out_free;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign act_in    = (in_data.active_channels > MAX_ACT) ? MAX_ACT
                                                           : in_data.active_channels;

    assign samples[0] = in_data.sample_0;
    assign samples[1] = in_data.sample_1;
    assign samples[2] = in_data.sample_2;
    assign samples[3] = in_data.sample_3;
    assign samples[4] = in_data.sample_4;
    assign samples[5] = in_data.sample_5;
    assign samples[6] = in_data.sample_6;
    assign samples[7] = in_data.sample_7;

    assign eo_hi           = eo_reg[23:16];
    assign lane_ctrl.load  = accept;
    assign lane_ctrl.mant  = mant_reg;
    assign lane_ctrl.shamt = 6'(8'd54 - eo_hi);
    assign lane_ctrl.rnd   = (eo_hi < 8'd48);

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        if (i < MAX_CHANNELS)
        begin : g_on
            lrsk_lane u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .sample (samples[i]),
                .active (act_in > 4'(i)),
                .ctrl   (lane_ctrl),
                .square (lane_sq[i]),
                .result (lane_out[i])
            );
        end
        else
        begin : g_off
            assign lane_sq[i]  = '0;
            assign lane_out[i] = '0;
        end
    end

    lrsk_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Arithmetic shared by the states.
    always_comb
    begin
        det_c    = (det_reg > ONE_Q24) ? ONE_Q24 : det_reg;
        inst     = div_quo[46:0];
        det_low  = {25'b0, phi_reg[0], 23'b0} + {1'b0, prod_reg[47:0]};
        det_step = 48'(phi_reg[48:1]) + 48'(det_low[48:24]);

        ir_c    = (ir_reg > ONE_Q16) ? ONE_Q16 : ir_reg;
        slope   = ONE_Q16 - ir_c;
        ov      = 17'(level_reg) - 17'(thr_reg);
        aov     = ov[16] ? 17'(-ov) : 17'(ov);
        t2_full = 18'(ov) * 18'sd2 + 18'($signed({1'b0, knee_reg}));

        log_idx = {1'b0, norm_reg[46:43]};
        frac    = log2_tab(log_idx) + 17'(prod_reg[28:16]);
        lg      = {1'b0, 6'd47 - z_reg, 16'b0} + 23'(frac);
        lg_max  = 23'd3014656;
        m_db    = 17'((prod_reg[39:0] + 40'd8388608) >> 24);

        sdiff   = 18'(g_reg) - 18'(target_reg);
        adiff   = sdiff[17] ? 18'(-sdiff) : 18'(sdiff);
        sm_c    = (target_reg < g_reg) ? ((att_reg > ONE_Q24) ? ONE_Q24 : att_reg)
                                       : ((rel_reg > ONE_Q24) ? ONE_Q24 : rel_reg);
        sm_step = prod_reg[41:24];
        g_new   = neg_reg ? (18'(target_reg) - 18'($signed({1'b0, sm_step[16:0]})))
                          : (18'(target_reg) + 18'($signed({1'b0, sm_step[16:0]})));

        a_new   = g_reg + 17'($signed({2'b0, mk_reg}));
        a_abs   = a_new[16] ? 17'(-a_new) : 17'(a_new);
        emag    = 21'((prod_reg[38:0] + 39'd128) >> 8);
        e_val   = a_reg[16] ? -24'($signed({1'b0, emag})) : 24'($signed({1'b0, emag}));
        exp_idx = {1'b0, eo_reg[15:12]};
    end

    // Shared multiplier operands, one product per state.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_DET_HI:
            begin
                mul_a = 30'(dlt_reg[46:23]);
                mul_b = det_c;
            end
            ST_DET_LO:
            begin
                mul_a = 30'(dlt_reg[22:0]);
                mul_b = det_c;
            end
            ST_LOG_MUL:
            begin
                mul_a = 30'(norm_reg[42:27]);
                mul_b = 25'(log2_tab(log_idx + 5'd1) - log2_tab(log_idx));
            end
            ST_LOG_DBM:
            begin
                mul_a = 30'(d_reg);
                mul_b = 25'd197283;
            end
            ST_KNEE_SQ:
            begin
                mul_a = 30'(t2_reg);
                mul_b = 25'(t2_reg);
            end
            ST_KNEE_NUM:
            begin
                mul_a = prod_reg[29:0];
                mul_b = 25'(slope);
            end
            ST_LIN_MUL:
            begin
                mul_a = 30'(ovp_reg);
                mul_b = 25'(slope);
            end
            ST_SMOOTH:
            begin
                mul_a = 30'(adiff);
                mul_b = sm_c;
            end
            ST_EXP_MUL:
            begin
                mul_a = 30'(a_abs);
                mul_b = 25'd10885;
            end
            ST_EXP_MANT:
            begin
                mul_a = 30'(eo_reg[11:0]);
                mul_b = 25'(exp2_tab(exp_idx + 5'd1) - exp2_tab(exp_idx));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        if (state_reg == ST_AVG && act_reg != 4'd0)
        begin
            div_start = 1'b1;
            div_num   = sum_reg;
            div_den   = DIV_DEN_W'(act_reg);
        end
        else if (state_reg == ST_KNEE_DIV)
        begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(prod_reg[46:0]) + (DIV_NUM_W'(knee_reg) << 18);
            div_den   = DIV_DEN_W'(knee_reg) << 19;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       state_next = in_valid ? ST_SQ : ST_IDLE;
            ST_SQ:         state_next = ST_SUM;
            ST_SUM:        state_next = (cnt_reg == LANE_IDX_W'(LANES - 1)) ? ST_AVG : ST_SUM;
            ST_AVG:        state_next = (act_reg != 4'd0) ? ST_AVG_WAIT : ST_DET_DIFF;
            ST_AVG_WAIT:   state_next = div_done ? ST_DET_DIFF : ST_AVG_WAIT;
            ST_DET_DIFF:   state_next = ST_DET_HI;
            ST_DET_HI:     state_next = ST_DET_LO;
            ST_DET_LO:     state_next = ST_DET_UPD;
            ST_DET_UPD:    state_next = ST_LOG_START;
            ST_LOG_START:  state_next = (ms_reg <= MS_FLOOR) ? ST_CURVE : ST_LOG_NORM;
            ST_LOG_NORM:   state_next = (nstep_reg == 3'd5) ? ST_LOG_MUL : ST_LOG_NORM;
            ST_LOG_MUL:    state_next = ST_LOG_DB;
            ST_LOG_DB:     state_next = ST_LOG_DBM;
            ST_LOG_DBM:    state_next = ST_LOG_LEV;
            ST_LOG_LEV:    state_next = ST_CURVE;
            ST_CURVE:      state_next = ST_KNEE_SQ;
            ST_KNEE_SQ:
            begin
                priority case (crv_reg)
                    CRV_KNEE:   state_next = ST_KNEE_NUM;
                    CRV_LINEAR: state_next = ST_LIN_MUL;
                    default:    state_next = ST_SMOOTH;
                endcase
            end
            ST_KNEE_NUM:   state_next = ST_KNEE_DIV;
            ST_KNEE_DIV:   state_next = ST_KNEE_WAIT;
            ST_KNEE_WAIT:  state_next = div_done ? ST_SMOOTH : ST_KNEE_WAIT;
            ST_LIN_MUL:    state_next = ST_LIN_RND;
            ST_LIN_RND:    state_next = ST_SMOOTH;
            ST_SMOOTH:     state_next = ST_SMOOTH_UPD;
            ST_SMOOTH_UPD: state_next = ST_EXP_MUL;
            ST_EXP_MUL:    state_next = ST_EXP_FRAC;
            ST_EXP_FRAC:   state_next = ST_EXP_MANT;
            ST_EXP_MANT:   state_next = ST_EXP_SUM;
            ST_EXP_SUM:    state_next = ST_SCALE_MUL;
            ST_SCALE_MUL:  state_next = ST_SCALE_SHF;
            ST_SCALE_SHF:  state_next = ST_DONE;
            ST_DONE:       state_next = out_free ? ST_IDLE : ST_DONE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // State, configuration and the result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= -16'sd5120;
            ir_reg        <= 17'd16384;
            knee_reg      <= 14'd1536;
            att_reg       <= 25'd16000000;
            rel_reg       <= 25'd16700000;
            det_reg       <= 25'd16777;
            mk_reg        <= 15'd0;
            cnt_reg       <= '0;
            nstep_reg     <= '0;
            act_reg       <= '0;
            ms_reg        <= '0;
            g_reg         <= '0;
            out_valid_reg <= 1'b0;
            crv_reg       <= CRV_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD: thr_reg  <= $signed(cfg_data[15:0]);
                    CFG_INV_RATIO: ir_reg   <= cfg_data[16:0];
                    CFG_KNEE:      knee_reg <= cfg_data[13:0];
                    CFG_ATTACK:    att_reg  <= cfg_data;
                    CFG_RELEASE:   rel_reg  <= cfg_data;
                    CFG_DETECTOR:  det_reg  <= cfg_data;
                    CFG_MAKEUP:    mk_reg   <= cfg_data[14:0];
                    default:       ;
                endcase
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg <= act_in;
                    end
                    cnt_reg <= '0;
                end
                ST_SUM:
                begin
                    cnt_reg <= cnt_reg + LANE_IDX_W'(1);
                end
                ST_DET_UPD:
                begin
                    ms_reg <= up_reg ? (ms_reg + det_step[46:0]) : (ms_reg - det_step[46:0]);
                end
                ST_LOG_START:
                begin
                    nstep_reg <= '0;
                end
                ST_LOG_NORM:
                begin
                    nstep_reg <= nstep_reg + 3'd1;
                end
                ST_CURVE:
                begin
                    if (knee_reg != 14'd0 && {aov, 1'b0} <= 18'(knee_reg))
                    begin
                        crv_reg <= CRV_KNEE;
                    end
                    else if (!ov[16] && ov != 17'sd0)
                    begin
                        crv_reg <= CRV_LINEAR;
                    end
                    else
                    begin
                        crv_reg <= CRV_ZERO;
                    end
                end
                ST_SMOOTH_UPD:
                begin
                    g_reg <= g_new[16:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= 55'(mul_a) * 55'(mul_b);
        unique case (state_reg)
            ST_IDLE:
            begin
                sum_reg <= '0;
            end
            ST_SUM:
            begin
                sum_reg <= sum_reg + SUM_W'(lane_sq[cnt_reg]);
            end
            ST_DET_DIFF:
            begin
                // With no active channel the average is zero.
                if (act_reg == 4'd0)
                begin
                    up_reg  <= 1'b0;
                    dlt_reg <= ms_reg;
                end
                else if (inst >= ms_reg)
                begin
                    up_reg  <= 1'b1;
                    dlt_reg <= inst - ms_reg;
                end
                else
                begin
                    up_reg  <= 1'b0;
                    dlt_reg <= ms_reg - inst;
                end
            end
            ST_DET_LO:
            begin
                phi_reg <= prod_reg[48:0];
            end
            ST_LOG_START:
            begin
                norm_reg  <= {1'b0, ms_reg};
                z_reg     <= '0;
                level_reg <= -16'sd30720;
            end
            ST_LOG_NORM:
            begin
                // Binary search for the leading one: 32, 16, 8, 4, 2, 1.
                unique case (nstep_reg)
                    3'd0:
                    begin
                        if (norm_reg[47:16] == '0)
                        begin
                            norm_reg <= norm_reg << 32;
                            z_reg    <= z_reg + 6'd32;
                        end
                    end
                    3'd1:
                    begin
                        if (norm_reg[47:32] == '0)
                        begin
                            norm_reg <= norm_reg << 16;
                            z_reg    <= z_reg + 6'd16;
                        end
                    end
                    3'd2:
                    begin
                        if (norm_reg[47:40] == '0)
                        begin
                            norm_reg <= norm_reg << 8;
                            z_reg    <= z_reg + 6'd8;
                        end
                    end
                    3'd3:
                    begin
                        if (norm_reg[47:44] == '0)
                        begin
                            norm_reg <= norm_reg << 4;
                            z_reg    <= z_reg + 6'd4;
                        end
                    end
                    3'd4:
                    begin
                        if (norm_reg[47:46] == '0)
                        begin
                            norm_reg <= norm_reg << 2;
                            z_reg    <= z_reg + 6'd2;
                        end
                    end
                    default:
                    begin
                        if (!norm_reg[47])
                        begin
                            norm_reg <= norm_reg << 1;
                            z_reg    <= z_reg + 6'd1;
                        end
                    end
                endcase
            end
            ST_LOG_DB:
            begin
                d_reg <= (lg >= lg_max) ? '0 : 22'(lg_max - lg);
            end
            ST_LOG_LEV:
            begin
                level_reg <= (m_db > 17'd30720) ? -16'sd30720 : -$signed(16'(m_db));
            end
            ST_CURVE:
            begin
                t2_reg  <= t2_full[14:0];
                ovp_reg <= ov[15:0];
                target_reg <= '0;
            end
            ST_KNEE_WAIT:
            begin
                target_reg <= -$signed(17'(div_quo[15:0]));
            end
            ST_LIN_RND:
            begin
                target_reg <= -$signed(17'((prod_reg[32:0] + 33'd32768) >> 16));
            end
            ST_SMOOTH:
            begin
                neg_reg <= sdiff[17];
            end
            ST_EXP_MUL:
            begin
                a_reg <= a_new;
            end
            ST_EXP_FRAC:
            begin
                eo_reg <= 24'(e_val + 24'sd2097152);
            end
            ST_EXP_SUM:
            begin
                mant_reg <= exp2_tab(exp_idx) + MANT_W'(prod_reg[24:12]);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg.out_sample_0    <= lane_out[0];
                    out_data_reg.out_sample_1    <= lane_out[1];
                    out_data_reg.out_sample_2    <= lane_out[2];
                    out_data_reg.out_sample_3    <= lane_out[3];
                    out_data_reg.out_sample_4    <= lane_out[4];
                    out_data_reg.out_sample_5    <= lane_out[5];
                    out_data_reg.out_sample_6    <= lane_out[6];
                    out_data_reg.out_sample_7    <= lane_out[7];
                    out_data_reg.applied_gain_db <= a_reg[15:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== test/linked_rms_soft_knee_compressor_top_tb.sv =====
// ----------------------------------------------------------------------------
// linked_rms_soft_knee_compressor_top_tb: self-checking bench of the compressor
// Frames are driven with random gaps and output stalls under several register
// settings; a bit-exact gain model predicts each scaled frame and its gain.
// ----------------------------------------------------------------------------
module linked_rms_soft_knee_compressor_top_tb;
    import lrsk_pkg::*;

class frame_scoreboard;
    // Register copies.
    int          thr;
    int unsigned inv_ratio;
    int unsigned knee;
    int unsigned atk;
    int unsigned rel;
    int unsigned det;
    int unsigned makeup;
    // Block state.
    longint unsigned ms_level;
    int          gain_q88;
    lrsk_out_t   pending[$];
    int          errors;
    int          checked;

    function void reset_state();
        thr = -5120; inv_ratio = 16384; knee = 1536; atk = 16000000;
        rel = 16700000; det = 16777; makeup = 0;
        ms_level = 0; gain_q88 = 0;
    endfunction

    function void set_reg(lrsk_cfg_idx_t idx, logic [24:0] v);
        case (idx)
            CFG_THRESHOLD: thr = $signed(v[15:0]);
            CFG_INV_RATIO: inv_ratio = v[16:0];
            CFG_KNEE:      knee = v[13:0];
            CFG_ATTACK:    atk = v;
            CFG_RELEASE:   rel = v;
            CFG_DETECTOR:  det = v;
            CFG_MAKEUP:    makeup = v[14:0];
            default: ;
        endcase
    endfunction

    function longint unsigned lim24(int unsigned c);
        return (c > 32'd16777216) ? 64'd16777216 : c;
    endfunction

    function longint unsigned mulq24(longint unsigned d, longint unsigned c);
        longint unsigned a, b;
        a = (d >> 23) * c;
        b = (d & 64'h7FFFFF) * c;
        return (a >> 1) + ((((a & 1) << 23) + b) >> 24);
    endfunction

    function int to_db(longint unsigned ms);
        int unsigned p, sh, idx;
        longint unsigned rem, t, frac, lg, d, m, t0, t1;
        if (ms <= 70) return -30720;
        p = 0;
        while (p < 62 && (ms >> (p + 1)) != 0) p++;
        sh = p - 4;
        idx = int'((ms >> sh) & 15);
        rem = ms & ((64'd1 << sh) - 1);
        t = (sh >= 16) ? rem >> (sh - 16) : rem << (16 - sh);
        t0 = log2_val(idx); t1 = log2_val(idx + 1);
        frac = t0 + (((t1 - t0) * t) >> 16);
        lg = longint'(p) * 65536 + frac;
        d = (lg >= 46 * 65536) ? 0 : 46 * 65536 - lg;
        m = (d * 197283 + (64'd1 << 23)) >> 24;
        if (m > 30720) return -30720;
        return -int'(m);
    endfunction

    function longint unsigned log2_val(int unsigned i);
        longint unsigned tab[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312,
            38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
        return tab[i];
    endfunction

    function longint unsigned exp2_val(int unsigned i);
        longint unsigned tab[17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990,
            88752, 92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};
        return tab[i];
    endfunction

    function int knee_curve(int x);
        longint ov, k, ir, slope, aov, t2;
        ov = longint'(x) - thr;
        k = knee;
        ir = (inv_ratio > 65536) ? 65536 : inv_ratio;
        slope = 65536 - ir;
        aov = (ov < 0) ? -ov : ov;
        if (k > 0 && 2 * aov <= k) begin
            t2 = 2 * ov + k;
            return -int'((slope * t2 * t2 + (524288 * k) / 2) / (524288 * k));
        end
        if (ov <= 0) return 0;
        return -int'((ov * slope + 32768) >>> 16);
    endfunction

    function logic [23:0] scale(longint s, longint unsigned mant, int ip);
        longint unsigned mag, r;
        longint y;
        int sh;
        mag = longint'((s < 0) ? -s : s) * mant;
        sh = 16 - ip;
        if (sh > 0) r = (mag + (64'd1 << (sh - 1))) >> sh;
        else r = mag << (-sh);
        if (r > 64'd8388608) r = 64'd8388608;
        y = (s < 0) ? -longint'(r) : longint'(r);
        if (y > 8388607) y = 8388607;
        return y[23:0];
    endfunction

    function void note_frame(lrsk_in_t f);
        longint s[8];
        longint unsigned sum, inst, c, mant, emag, eo, fp, adiff, stp, m;
        int act, target, a, ip, idx;
        longint diff, e;
        lrsk_out_t r;
        s[0] = f.sample_0; s[1] = f.sample_1; s[2] = f.sample_2; s[3] = f.sample_3;
        s[4] = f.sample_4; s[5] = f.sample_5; s[6] = f.sample_6; s[7] = f.sample_7;
        act = int'(f.active_channels);
        if (act > 8) act = 8;
        sum = 0;
        for (int i = 0; i < act; i++) begin
            m = (s[i] < 0) ? -s[i] : s[i];
            sum += m * m;
        end
        inst = (act > 0) ? sum / act : 0;
        c = lim24(det);
        if (inst >= ms_level) ms_level += mulq24(inst - ms_level, c);
        else ms_level -= mulq24(ms_level - inst, c);
        target = knee_curve(to_db(ms_level));
        c = lim24((target < gain_q88) ? atk : rel);
        diff = longint'(gain_q88) - target;
        adiff = (diff < 0) ? -diff : diff;
        stp = (adiff * c) >> 24;
        gain_q88 = target + ((diff < 0) ? -int'(stp) : int'(stp));
        a = gain_q88 + int'(makeup);
        emag = (longint'((a < 0) ? -a : a) * 10885 + 128) >> 8;
        e = (a < 0) ? -longint'(emag) : longint'(emag);
        eo = e + 32 * 65536;
        ip = int'(eo >> 16) - 32;
        fp = eo & 16'hFFFF;
        idx = int'(fp >> 12);
        mant = exp2_val(idx) + (((exp2_val(idx + 1) - exp2_val(idx)) * (fp & 12'hFFF)) >> 12);
        r = '0;
        if (act > 0) r.out_sample_0 = scale(s[0], mant, ip);
        if (act > 1) r.out_sample_1 = scale(s[1], mant, ip);
        if (act > 2) r.out_sample_2 = scale(s[2], mant, ip);
        if (act > 3) r.out_sample_3 = scale(s[3], mant, ip);
        if (act > 4) r.out_sample_4 = scale(s[4], mant, ip);
        if (act > 5) r.out_sample_5 = scale(s[5], mant, ip);
        if (act > 6) r.out_sample_6 = scale(s[6], mant, ip);
        if (act > 7) r.out_sample_7 = scale(s[7], mant, ip);
        r.applied_gain_db = a[15:0];
        pending.push_back(r);
    endfunction

    function void compare(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_frame(lrsk_out_t got);
        lrsk_out_t w;
        if (pending.size() == 0) begin
            $display("%0t unexpected result expected none actual %h", $time, got);
            errors++;
            return;
        end
        w = pending.pop_front();
        checked++;
        compare("out_sample_0", w.out_sample_0, got.out_sample_0);
        compare("out_sample_1", w.out_sample_1, got.out_sample_1);
        compare("out_sample_2", w.out_sample_2, got.out_sample_2);
        compare("out_sample_3", w.out_sample_3, got.out_sample_3);
        compare("out_sample_4", w.out_sample_4, got.out_sample_4);
        compare("out_sample_5", w.out_sample_5, got.out_sample_5);
        compare("out_sample_6", w.out_sample_6, got.out_sample_6);
        compare("out_sample_7", w.out_sample_7, got.out_sample_7);
        compare("applied_gain_db", w.applied_gain_db, got.applied_gain_db);
    endfunction
endclass

    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    lrsk_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    lrsk_out_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [24:0] cfg_data;

    frame_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    int frames_sent;
    int cfg_writes;

    linked_rms_soft_knee_compressor_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side: random stall at the falling edge, sampling at the rising edge.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_frame(out_data);
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(lrsk_cfg_idx_t idx, logic [24:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, v);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic send_frame(lrsk_in_t f);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= f;
        do @(posedge clk); while (in_stall);
        sb.note_frame(f);
        frames_sent++;
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    function automatic logic [23:0] rand_sample(int kind);
        case (kind)
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'($urandom_range(255) - 128);
            3: return 24'($urandom_range(65535) - 32768);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic lrsk_in_t rand_frame(int loudness);
        lrsk_in_t f;
        int kind;
        f.active_channels = 4'(($urandom_range(9) == 0) ? $urandom_range(15)
                                                         : $urandom_range(8));
        kind = (loudness >= 0) ? loudness : int'($urandom_range(5));
        f.sample_0 = rand_sample(kind); f.sample_1 = rand_sample(kind);
        f.sample_2 = rand_sample(kind); f.sample_3 = rand_sample(kind);
        f.sample_4 = rand_sample(kind); f.sample_5 = rand_sample(kind);
        f.sample_6 = rand_sample(kind); f.sample_7 = rand_sample(kind);
        return f;
    endfunction

    task automatic random_block(int n);
        int loud;
        loud = int'($urandom_range(5));
        for (int i = 0; i < n; i++)
        begin
            // Mostly sustained bursts at one loudness so the detector settles.
            if ($urandom_range(19) == 0) loud = int'($urandom_range(5));
            send_frame(rand_frame(($urandom_range(3) == 0) ? -1 : loud));
        end
    endtask

    task automatic random_settings();
        write_reg(CFG_THRESHOLD, 25'($signed(-$urandom_range(30720))));
        write_reg(CFG_INV_RATIO, 25'($urandom_range(3) == 0 ? $urandom_range(131071)
                                                             : $urandom_range(65536)));
        write_reg(CFG_KNEE, 25'($urandom_range(3) == 0 ? $urandom_range(16383)
                                                        : $urandom_range(12288)));
        write_reg(CFG_ATTACK, 25'($urandom_range(3) == 0 ? $urandom
                                                          : $urandom_range(16777216)));
        write_reg(CFG_RELEASE, 25'($urandom_range(3) == 0 ? $urandom
                                                           : $urandom_range(16777216)));
        write_reg(CFG_DETECTOR, 25'($urandom_range(16777216)));
        write_reg(CFG_MAKEUP, 25'($urandom_range(32767)));
    endtask

    initial
    begin
        lrsk_in_t f;
        int phase_pct[4][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{6, 6}};
        sb = new();
        sb.reset_state();
        rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        send_idle_pct = 0; recv_stall_pct = 0; quiet_cycles = 0;
        frames_sent = 0; cfg_writes = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, inactive lanes, zero and excess channel counts.
        f = '0; f.active_channels = 4'd8;
        f.sample_0 = 24'h800000; f.sample_1 = 24'h7FFFFF; f.sample_2 = 24'h800000;
        f.sample_3 = 24'h7FFFFF; f.sample_4 = 24'h800000; f.sample_5 = 24'h7FFFFF;
        f.sample_6 = 24'h800000; f.sample_7 = 24'h7FFFFF;
        for (int i = 0; i < 4; i++) send_frame(f);
        f.active_channels = 4'd15; send_frame(f);
        f.active_channels = 4'd0;  send_frame(f);
        f.active_channels = 4'd3;  send_frame(f);
        f = '0; f.active_channels = 4'd8; send_frame(f);
        drain();
        // Hard knee, limiter, instant attack, held release, makeup of 30720.
        write_reg(CFG_KNEE, 25'd0);
        write_reg(CFG_INV_RATIO, 25'd0);
        write_reg(CFG_ATTACK, 25'd0);
        write_reg(CFG_RELEASE, 25'h1FFFFFF);
        write_reg(CFG_DETECTOR, 25'd16777216);
        write_reg(CFG_MAKEUP, 25'd30720);
        write_reg(CFG_THRESHOLD, 25'h0);
        for (int i = 0; i < 6; i++) send_frame(rand_frame(i % 5));
        drain();
        // Inverse ratio above one (clamped to one), wide knee, positive threshold, instant detector, held attack.
        write_reg(CFG_INV_RATIO, 25'h1FFFF);
        write_reg(CFG_KNEE, 25'd12288);
        write_reg(CFG_THRESHOLD, 25'h07FFF);
        write_reg(CFG_DETECTOR, 25'h1FFFFFF);
        write_reg(CFG_MAKEUP, 25'h7FFF);
        write_reg(CFG_ATTACK, 25'd16777216);
        for (int i = 0; i < 6; i++) send_frame(rand_frame(-1));
        f = '0; send_frame(f);
        drain();
        write_reg(CFG_THRESHOLD, 25'($signed(-30720)));
        write_reg(CFG_MAKEUP, 25'd0);

        for (int blk = 0; blk < 16; blk++)
        begin
            send_idle_pct  = phase_pct[blk % 4][0];
            recv_stall_pct = phase_pct[blk % 4][1];
            if (blk % 5 == 4) random_settings();
            random_block(112);
            // The sender holds off here until everything outstanding has come back.
            drain();
        end
        send_idle_pct = 0; recv_stall_pct = 0;
        drain();
        $display("Sent %0d frames, checked %0d results, %0d register writes",
                 frames_sent, sb.checked, cfg_writes);
        $display("over four idle/stall mixes and several threshold/ratio/knee settings.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lrsk_pkg.sv
hw/rtl/lrsk_lane.sv
hw/rtl/lrsk_div.sv
hw/rtl/linked_rms_soft_knee_compressor_top.sv
test/linked_rms_soft_knee_compressor_top_tb.sv
